[hw/rtl/lcfc_pkg.sv]
// Shared constants, types and helper functions of the load-cell filter chain.
package lcfc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int NOW_W = 32;
    localparam int TENTHS_W = 16;
    localparam int GRAMS_W = 13;
    localparam int SUM_OUT_W = 27;
    localparam int OFFSET_W = 27;
    localparam int GAIN_W = 32;
    localparam int INTERVAL_W = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;

    localparam int HISTORY_DEPTH_DEF = 200;
    localparam int AVERAGE_DEPTH_DEF = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam int TENTHS_LIMIT = 30000;
    localparam int LOOK_EXTRA = 20;
    localparam int INTERVAL_RESET = 200;

    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_OFFSET = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_Q24 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL = 2'd2;

    typedef struct packed {
        logic signed [TENTHS_W-1:0] tenths;
        logic signed [GRAMS_W-1:0] weight;
        logic [SUM_OUT_W-1:0] sum;
        logic [NOW_W-1:0] now;
    } work_t;

    function automatic logic signed [SAMPLE_W-1:0] med3(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic signed [SAMPLE_W-1:0] c
    );
        logic signed [SAMPLE_W-1:0] m;
        if ((b <= a && a <= c) || (c <= a && a <= b))
        begin
            m = a;
        end
        else if ((a <= b && b <= c) || (c <= b && b <= a))
        begin
            m = b;
        end
        else
        begin
            m = c;
        end
        return m;
    endfunction

    // Truncating divide by ten, exact for magnitudes up to 2^15 + 2^14.
    function automatic logic signed [GRAMS_W-1:0] div10(input logic signed [16:0] x);
        logic [16:0] mag;
        logic [31:0] prod;
        logic [GRAMS_W-1:0] q;
        mag = x[16] ? 17'(-x) : 17'(x);
        prod = 32'(mag[15:0]) * 32'd52429;
        q = GRAMS_W'(prod >> 19);
        return x[16] ? signed'(GRAMS_W'(-q)) : signed'(q);
    endfunction

endpackage

[hw/rtl/lcfc_if.sv]
// Valid/ready channel interfaces for samples and results.
interface lcfc_in_if;
    logic valid;
    logic ready;
    logic signed [lcfc_pkg::SAMPLE_W-1:0] raw_sample;
    logic [lcfc_pkg::NOW_W-1:0] now_ms;

    modport source(output valid, output raw_sample, output now_ms, input ready);
    modport sink(input valid, input raw_sample, input now_ms, output ready);
endinterface

interface lcfc_out_if;
    logic valid;
    logic ready;
    logic signed [lcfc_pkg::GRAMS_W-1:0] weight_grams;
    logic signed [lcfc_pkg::GRAMS_W-1:0] display_weight_grams;
    logic signed [lcfc_pkg::SUM_OUT_W-1:0] filtered_sum;
    logic display_updated;

    modport source(output valid, output weight_grams, output display_weight_grams,
                   output filtered_sum, output display_updated, input ready);
    modport sink(input valid, input weight_grams, input display_weight_grams,
                 input filtered_sum, input display_updated, output ready);
endinterface

[hw/rtl/lcfc_front.sv]
// Front end: raw median, AVERAGE_DEPTH-deep (default five) running sum, tare, gain and clamp to tenths.
module lcfc_front #(
    parameter int AVERAGE_DEPTH = lcfc_pkg::AVERAGE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    lcfc_in_if.sink sample,
    input  logic signed [lcfc_pkg::OFFSET_W-1:0] zero_offset,
    input  logic signed [lcfc_pkg::GAIN_W-1:0] gain_q24,
    output logic push_valid,
    input  logic push_ready,
    output lcfc_pkg::work_t push_word
);

    localparam int SW = lcfc_pkg::SAMPLE_W;
    localparam int SLOT_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int SUM_W = SW + $clog2(AVERAGE_DEPTH);
    localparam int SUM_X = (SUM_W > lcfc_pkg::SUM_OUT_W) ? SUM_W : lcfc_pkg::SUM_OUT_W;
    localparam int DIFF_W = SUM_X + 1;
    localparam int ACC_W = 64;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_DIFF = 3'd1;
    localparam logic [2:0] F_MLO = 3'd2;
    localparam logic [2:0] F_MHI = 3'd3;
    localparam logic [2:0] F_SCALE = 3'd4;
    localparam logic [2:0] F_TENTH = 3'd5;
    localparam logic [2:0] F_PUSH = 3'd6;

    logic [2:0] state_reg, state_next;
    logic signed [SW-1:0] raw_reg [3];
    logic [1:0] raw_slot_reg;
    logic signed [SW-1:0] med_reg [AVERAGE_DEPTH];
    logic [SLOT_W-1:0] med_slot_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [lcfc_pkg::NOW_W-1:0] now_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [lcfc_pkg::TENTHS_W-1:0] tenths_reg;

    logic accept;
    logic signed [SW-1:0] w0, w1, w2, med_new;
    logic signed [SUM_X-1:0] sum_ext;
    logic signed [DIFF_W+16:0] p_lo;
    logic signed [DIFF_W+15:0] p_hi;
    logic signed [ACC_W-1:0] q_raw, q_fix;

    assign accept = sample.valid && sample.ready;
    assign sample.ready = (state_reg == F_IDLE);

    assign w0 = (raw_slot_reg == 2'd0) ? sample.raw_sample : raw_reg[0];
    assign w1 = (raw_slot_reg == 2'd1) ? sample.raw_sample : raw_reg[1];
    assign w2 = (raw_slot_reg == 2'd2) ? sample.raw_sample : raw_reg[2];
    assign med_new = lcfc_pkg::med3(w0, w1, w2);

    assign sum_ext = SUM_X'(sum_reg);
    assign p_lo = diff_reg * signed'({1'b0, gain_q24[15:0]});
    assign p_hi = diff_reg * signed'(gain_q24[31:16]);
    assign q_raw = acc_reg >>> 24;
    assign q_fix = (acc_reg[ACC_W-1] && (acc_reg[23:0] != 24'd0)) ? q_raw + 64'sd1 : q_raw;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (accept) state_next = F_DIFF;
            F_DIFF:  state_next = F_MLO;
            F_MLO:   state_next = F_MHI;
            F_MHI:   state_next = F_SCALE;
            F_SCALE: state_next = F_TENTH;
            F_TENTH: state_next = F_PUSH;
            F_PUSH:  if (push_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            raw_slot_reg <= 2'd0;
            med_slot_reg <= '0;
            sum_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                raw_reg[i] <= '0;
            end
            for (int i = 0; i < AVERAGE_DEPTH; i++)
            begin
                med_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                raw_reg[raw_slot_reg] <= sample.raw_sample;
                raw_slot_reg <= (raw_slot_reg == 2'd2) ? 2'd0 : raw_slot_reg + 2'd1;
                med_reg[med_slot_reg] <= med_new;
                med_slot_reg <= (med_slot_reg == SLOT_W'(AVERAGE_DEPTH - 1)) ? '0
                                : med_slot_reg + 1'b1;
                sum_reg <= sum_reg + SUM_W'(med_new) - SUM_W'(med_reg[med_slot_reg]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg <= sample.now_ms;
        end
        case (state_reg)
            F_DIFF:  diff_reg <= DIFF_W'(sum_ext) - DIFF_W'(zero_offset);
            F_MLO:   acc_reg <= ACC_W'(p_lo);
            F_MHI:   acc_reg <= acc_reg + (ACC_W'(p_hi) <<< 16);
            F_SCALE: acc_reg <= (acc_reg <<< 3) + (acc_reg <<< 1);
            F_TENTH:
            begin
                if (q_fix < -ACC_W'(lcfc_pkg::TENTHS_LIMIT))
                begin
                    tenths_reg <= -16'(lcfc_pkg::TENTHS_LIMIT);
                end
                else if (q_fix > ACC_W'(lcfc_pkg::TENTHS_LIMIT))
                begin
                    tenths_reg <= 16'(lcfc_pkg::TENTHS_LIMIT);
                end
                else
                begin
                    tenths_reg <= 16'(q_fix);
                end
            end
            default: ;
        endcase
    end

    assign push_valid = (state_reg == F_PUSH);
    assign push_word.tenths = tenths_reg;
    assign push_word.weight = lcfc_pkg::div10(17'(tenths_reg));
    assign push_word.sum = sum_ext[lcfc_pkg::SUM_OUT_W-1:0];
    assign push_word.now = now_reg;

endmodule

[hw/rtl/lcfc_queue.sv]
// Short word queue between the front and back ends.
module lcfc_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  lcfc_pkg::work_t push_word,
    output logic pop_valid,
    input  logic pop_ready,
    output lcfc_pkg::work_t pop_word
);

    localparam int DEPTH = lcfc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcfc_pkg::work_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign push = push_valid && push_ready;
    assign pop = pop_valid && pop_ready;
    assign pop_word = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

[hw/rtl/lcfc_div.sv]
// Radix-2 restoring signed-by-unsigned divider, truncating toward zero.
module lcfc_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic done,
    output logic signed [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic busy_reg, done_reg, neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] shift_reg, shift_next;
    logic [DEN_W-1:0] rem_reg, rem_next, den_reg;
    logic [DEN_W:0] rem_sh;
    logic ge;
    logic signed [NUM_W-1:0] quo_reg;

    assign rem_sh = {rem_reg, shift_reg[NUM_W-1]};
    assign ge = (rem_sh >= {1'b0, den_reg});
    assign rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
    assign shift_next = {shift_reg[NUM_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            shift_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_next;
            rem_reg <= rem_next;
            if (cnt_reg == CNT_W'(1))
            begin
                quo_reg <= neg_reg ? signed'(NUM_W'(-shift_next)) : signed'(shift_next);
            end
        end
    end

    assign done = done_reg;
    assign quo = quo_reg;

endmodule

[hw/rtl/lcfc_back.sv]
// Back end: tenths history, adaptive window mean and display median.
module lcfc_back #(
    parameter int HISTORY_DEPTH = lcfc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [lcfc_pkg::INTERVAL_W-1:0] display_interval_ms,
    input  logic pop_valid,
    output logic pop_ready,
    input  lcfc_pkg::work_t pop_word,
    lcfc_out_if.source result
);

    localparam int TW = lcfc_pkg::TENTHS_W;
    localparam int GW = lcfc_pkg::GRAMS_W;
    localparam int HS_W = $clog2(HISTORY_DEPTH);
    localparam int LEN_W = $clog2(HISTORY_DEPTH + 1);
    localparam int HSUM_W = TW + $clog2(HISTORY_DEPTH);
    localparam int LOOK_W = 23;
    localparam int MEAN_MAG_W = HSUM_W - 1;
    localparam int MEAN_SH = MEAN_MAG_W + $clog2(HISTORY_DEPTH);
    localparam int RECIP_W = MEAN_MAG_W + 2;
    localparam int MEAN_PROD_W = MEAN_MAG_W + RECIP_W;
    localparam longint MEAN_RECIP = ((longint'(1) <<< MEAN_SH) + longint'(HISTORY_DEPTH) - 1)
                                    / longint'(HISTORY_DEPTH);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_RD = 4'd1;
    localparam logic [3:0] B_MEAN = 4'd2;
    localparam logic [3:0] B_LOOK = 4'd3;
    localparam logic [3:0] B_WALK = 4'd4;
    localparam logic [3:0] B_DSTART = 4'd5;
    localparam logic [3:0] B_DWAIT = 4'd6;
    localparam logic [3:0] B_DISP = 4'd7;

    logic [3:0] state_reg, state_next;
    lcfc_pkg::work_t item_reg;
    logic [HS_W-1:0] hs_reg, walk_addr_reg, rd_addr;
    logic signed [TW-1:0] hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] hist_valid_reg;
    logic signed [TW-1:0] rd_data_reg, rd_val;
    logic rd_ok_reg, wr_en;
    logic signed [HSUM_W-1:0] hsum_reg, dyn_acc_reg;
    logic signed [TW-1:0] hmean_reg, dyn_reg;
    logic [LEN_W-1:0] look_reg, issue_cnt_reg, acc_cnt_reg;
    logic rdv_reg;
    logic signed [GW-1:0] round_reg [3];
    logic [1:0] round_slot_reg;
    logic [lcfc_pkg::NOW_W-1:0] last_reg;
    logic signed [GW-1:0] shown_reg;

    logic out_valid_reg, out_upd_reg;
    logic signed [GW-1:0] out_weight_reg, out_disp_reg;
    logic [lcfc_pkg::SUM_OUT_W-1:0] out_sum_reg;

    logic div_start, div_done;
    logic signed [HSUM_W-1:0] div_num, div_quo;
    logic [LEN_W-1:0] div_den;

    logic [MEAN_MAG_W-1:0] hsum_mag;
    logic [MEAN_PROD_W-1:0] mean_prod;
    logic [TW-1:0] mean_mag;

    logic signed [16:0] dev_d;
    logic [15:0] dev_a;
    logic [LOOK_W-1:0] dev10;
    logic signed [LOOK_W-1:0] look_raw;
    logic [LEN_W-1:0] look_clamped;
    logic issuing, out_free, upd, walk_last;
    logic signed [GW-1:0] rnd, r0, r1, r2, med_disp;

    assign pop_ready = (state_reg == B_IDLE);
    assign rd_addr = (state_reg == B_WALK) ? walk_addr_reg : hs_reg;
    assign wr_en = (state_reg == B_RD);
    assign rd_val = rd_ok_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[hs_reg] <= item_reg.tenths;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                hist_valid_reg[hs_reg] <= 1'b1;
            end
            rd_ok_reg <= hist_valid_reg[rd_addr];
        end
    end

    assign hsum_mag = hsum_reg[HSUM_W-1] ? MEAN_MAG_W'(-hsum_reg) : MEAN_MAG_W'(hsum_reg);
    assign mean_prod = MEAN_PROD_W'(hsum_mag) * MEAN_PROD_W'(MEAN_RECIP);
    assign mean_mag = TW'(mean_prod >> MEAN_SH);

    assign div_start = (state_reg == B_DSTART);
    assign div_num = dyn_acc_reg;
    assign div_den = look_reg;

    lcfc_div #(
        .NUM_W(HSUM_W),
        .DEN_W(LEN_W)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .num(div_num),
        .den(div_den),
        .done(div_done),
        .quo(div_quo)
    );

    assign dev_d = 17'(hmean_reg) - 17'(item_reg.tenths);
    assign dev_a = dev_d[16] ? 16'(-dev_d) : 16'(dev_d);
    assign dev10 = LOOK_W'({dev_a, 3'b000}) + LOOK_W'({dev_a, 1'b0});
    assign look_raw = signed'(LOOK_W'(lcfc_pkg::LOOK_EXTRA + HISTORY_DEPTH)) - signed'(dev10);
    always_comb
    begin
        if (look_raw < signed'(LOOK_W'(1)))
        begin
            look_clamped = LEN_W'(1);
        end
        else if (look_raw > signed'(LOOK_W'(HISTORY_DEPTH)))
        begin
            look_clamped = LEN_W'(HISTORY_DEPTH);
        end
        else
        begin
            look_clamped = LEN_W'(look_raw);
        end
    end

    assign issuing = (issue_cnt_reg != look_reg);
    assign walk_last = rdv_reg && (LEN_W'(acc_cnt_reg + 1'b1) == look_reg);
    assign out_free = !out_valid_reg || result.ready;
    assign upd = (item_reg.now - last_reg) > lcfc_pkg::NOW_W'(display_interval_ms);
    assign rnd = lcfc_pkg::div10(17'(dyn_reg) + 17'sd5);
    assign r0 = (round_slot_reg == 2'd0) ? rnd : round_reg[0];
    assign r1 = (round_slot_reg == 2'd1) ? rnd : round_reg[1];
    assign r2 = (round_slot_reg == 2'd2) ? rnd : round_reg[2];
    assign med_disp = GW'(lcfc_pkg::med3(24'(r0), 24'(r1), 24'(r2)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:   if (pop_valid) state_next = B_RD;
            B_RD:     state_next = B_MEAN;
            B_MEAN:   state_next = B_LOOK;
            B_LOOK:   state_next = B_WALK;
            B_WALK:   if (walk_last) state_next = B_DSTART;
            B_DSTART: state_next = B_DWAIT;
            B_DWAIT:  if (div_done) state_next = B_DISP;
            B_DISP:   if (out_free) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            hs_reg <= '0;
            hsum_reg <= '0;
            round_slot_reg <= 2'd0;
            last_reg <= '0;
            shown_reg <= '0;
            out_valid_reg <= 1'b0;
            rdv_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                round_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_DISP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_RD:
                    hsum_reg <= hsum_reg - HSUM_W'(rd_val) + HSUM_W'(item_reg.tenths);
                B_LOOK:
                    rdv_reg <= 1'b0;
                B_WALK:
                    rdv_reg <= issuing;
                B_DISP:
                begin
                    if (out_free)
                    begin
                        hs_reg <= (hs_reg == HS_W'(HISTORY_DEPTH - 1)) ? '0 : hs_reg + 1'b1;
                        if (upd)
                        begin
                            round_reg[round_slot_reg] <= rnd;
                            round_slot_reg <= (round_slot_reg == 2'd2) ? 2'd0
                                              : round_slot_reg + 2'd1;
                            last_reg <= item_reg.now;
                            shown_reg <= med_disp;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
                if (pop_valid) item_reg <= pop_word;
            B_MEAN:
                hmean_reg <= hsum_reg[HSUM_W-1] ? signed'(TW'(-mean_mag)) : signed'(mean_mag);
            B_LOOK:
            begin
                look_reg <= look_clamped;
                walk_addr_reg <= hs_reg;
                issue_cnt_reg <= '0;
                acc_cnt_reg <= '0;
                dyn_acc_reg <= '0;
            end
            B_WALK:
            begin
                if (issuing)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    walk_addr_reg <= (walk_addr_reg == '0) ? HS_W'(HISTORY_DEPTH - 1)
                                     : walk_addr_reg - 1'b1;
                end
                if (rdv_reg)
                begin
                    dyn_acc_reg <= dyn_acc_reg + HSUM_W'(rd_val);
                    acc_cnt_reg <= acc_cnt_reg + 1'b1;
                end
            end
            B_DWAIT:
                if (div_done) dyn_reg <= TW'(div_quo);
            B_DISP:
            begin
                if (out_free)
                begin
                    out_weight_reg <= item_reg.weight;
                    out_disp_reg <= upd ? med_disp : shown_reg;
                    out_sum_reg <= item_reg.sum;
                    out_upd_reg <= upd;
                end
            end
            default: ;
        endcase
    end

    assign result.valid = out_valid_reg;
    assign result.weight_grams = out_weight_reg;
    assign result.display_weight_grams = out_disp_reg;
    assign result.filtered_sum = signed'(out_sum_reg);
    assign result.display_updated = out_upd_reg;

    a_hs_range: assert property (@(posedge clk) disable iff (!rst_n)
        hs_reg < HS_W'(HISTORY_DEPTH))
        else $error("history slot out of range");

    a_look_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_WALK |-> (look_reg != '0 && look_reg <= LEN_W'(HISTORY_DEPTH)))
        else $error("window length out of range");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == B_DWAIT)
        else $error("divider finished outside the wait state");

    a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_WALK |-> acc_cnt_reg < look_reg)
        else $error("window walk overran its length");

endmodule

[hw/rtl/load_cell_filter_chain.sv]
// Top level of the load-cell filter chain: config registers, front, queue, back.
//
//  channel  | dir | handshake    | word
//  sample   | in  | valid/ready  | raw_sample, now_ms
//  result   | out | valid/ready  | weight_grams, display_weight_grams, filtered_sum,
//           |     |              | display_updated
//  cfg      | in  | cfg_we       | cfg_index, cfg_data
//
// Front passes each sample through tare, two 16-bit gain partial products, scale, clamp;
// it takes no new sample until its word is pushed. Back walks the last L history entries,
// L the window length, with one read a cycle of the history memory, then a serial
// divider forms their mean; it takes no new word until its result can be registered.
// Reset clears all filter state at once; history entries carry valid bits.
// A two-word queue lets the front accept while the back works or the result stalls.
module load_cell_filter_chain #(
    parameter int HISTORY_DEPTH = lcfc_pkg::HISTORY_DEPTH_DEF,
    parameter int AVERAGE_DEPTH = lcfc_pkg::AVERAGE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    lcfc_in_if.sink sample,
    lcfc_out_if.source result,
    input  logic cfg_we,
    input  logic [lcfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lcfc_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic signed [lcfc_pkg::OFFSET_W-1:0] zero_offset_reg;
    logic signed [lcfc_pkg::GAIN_W-1:0] gain_q24_reg;
    logic [lcfc_pkg::INTERVAL_W-1:0] interval_reg;

    logic push_valid, push_ready, pop_valid, pop_ready;
    lcfc_pkg::work_t push_word, pop_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg <= '0;
            gain_q24_reg <= '0;
            interval_reg <= lcfc_pkg::INTERVAL_W'(lcfc_pkg::INTERVAL_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcfc_pkg::CFG_ZERO_OFFSET:
                    zero_offset_reg <= signed'(cfg_data[lcfc_pkg::OFFSET_W-1:0]);
                lcfc_pkg::CFG_GAIN_Q24:
                    gain_q24_reg <= signed'(cfg_data);
                lcfc_pkg::CFG_INTERVAL:
                    interval_reg <= cfg_data[lcfc_pkg::INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    lcfc_front #(
        .AVERAGE_DEPTH(AVERAGE_DEPTH)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample),
        .zero_offset(zero_offset_reg),
        .gain_q24(gain_q24_reg),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_word(push_word)
    );

    lcfc_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_word(push_word),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_word(pop_word)
    );

    lcfc_back #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .display_interval_ms(interval_reg),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .pop_word(pop_word),
        .result(result)
    );

endmodule

[test/tb_lcfc_pkg.sv]
// Shared testbench types for the load-cell filter chain bench.
package tb_lcfc_pkg;

    typedef struct packed {
        logic signed [12:0] weight;
        logic signed [12:0] shown;
        logic [26:0] sum;
        logic updated;
    } weight_word_t;

endpackage

[test/tb_load_cell_filter_chain.sv]
// Self-checking bench for the load-cell filter chain with a built-in predictor.
module tb_load_cell_filter_chain;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDEPTH = 200;
    localparam int ADEPTH = 5;
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [lcfc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lcfc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    lcfc_in_if sample_ch();
    lcfc_out_if result_ch();

    load_cell_filter_chain u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample_ch.sink),
        .result(result_ch.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // predictor state
    logic signed [26:0] tare;
    logic signed [31:0] gain;
    logic [15:0] interval_ms;
    int raw_ring[3];
    int raw_pos;
    int med_ring[ADEPTH];
    int med_pos;
    int hist_ring[HDEPTH];
    int hist_pos;
    int grams_ring[3];
    int grams_pos;
    logic [31:0] last_ms;
    int shown_grams;

    tb_lcfc_pkg::weight_word_t expected_words[$];
    int errors = 0;
    longint cycles = 0;
    int words_seen = 0;
    int updates_seen = 0;
    int clamps_seen = 0;
    bit stall_enable = 1'b1;
    logic [31:0] clock_ms = 0;

    function automatic int median3(int a, int b, int c);
        if ((b <= a && a <= c) || (c <= a && a <= b)) return a;
        if ((a <= b && b <= c) || (c <= b && b <= a)) return b;
        return c;
    endfunction

    task automatic reset_predictor();
        tare = 0;
        gain = 0;
        interval_ms = 16'(lcfc_pkg::INTERVAL_RESET);
        raw_ring = '{default: 0};
        med_ring = '{default: 0};
        hist_ring = '{default: 0};
        grams_ring = '{default: 0};
        raw_pos = 0;
        med_pos = 0;
        hist_pos = 0;
        grams_pos = 0;
        last_ms = 0;
        shown_grams = 0;
    endtask

    task automatic predict_weight(input logic signed [23:0] raw, input logic [31:0] now);
        longint total;
        longint prod;
        longint tenths;
        longint hsum;
        longint hmean;
        longint dev;
        longint look;
        longint dyn;
        tb_lcfc_pkg::weight_word_t w;
        raw_ring[raw_pos] = raw;
        raw_pos = (raw_pos + 1) % 3;
        med_ring[med_pos] = median3(raw_ring[0], raw_ring[1], raw_ring[2]);
        med_pos = (med_pos + 1) % ADEPTH;
        total = 0;
        foreach (med_ring[i]) total += med_ring[i];
        prod = (total - longint'(tare)) * longint'(gain) * 10;
        tenths = prod / (64'sd1 <<< 24);
        if (tenths < -lcfc_pkg::TENTHS_LIMIT) tenths = -lcfc_pkg::TENTHS_LIMIT;
        else if (tenths > lcfc_pkg::TENTHS_LIMIT) tenths = lcfc_pkg::TENTHS_LIMIT;
        if (tenths == lcfc_pkg::TENTHS_LIMIT || tenths == -lcfc_pkg::TENTHS_LIMIT)
            clamps_seen++;
        hist_ring[hist_pos] = int'(tenths);
        hsum = 0;
        foreach (hist_ring[i]) hsum += hist_ring[i];
        hmean = hsum / HDEPTH;
        dev = hmean - tenths;
        if (dev < 0) dev = -dev;
        look = lcfc_pkg::LOOK_EXTRA + HDEPTH - dev * 10;
        if (look < 1) look = 1;
        if (look > HDEPTH) look = HDEPTH;
        dyn = 0;
        for (int i = 0; i < look; i++) dyn += hist_ring[(hist_pos + HDEPTH - i) % HDEPTH];
        dyn = dyn / look;
        hist_pos = (hist_pos + 1) % HDEPTH;
        w.updated = 1'b0;
        if (32'(now - last_ms) > 32'(interval_ms))
        begin
            grams_ring[grams_pos] = int'((dyn + 5) / 10);
            grams_pos = (grams_pos + 1) % 3;
            last_ms = now;
            shown_grams = median3(grams_ring[0], grams_ring[1], grams_ring[2]);
            w.updated = 1'b1;
        end
        w.weight = 13'(tenths / 10);
        w.shown = 13'(shown_grams);
        w.sum = 27'(total);
        expected_words.push_back(w);
    endtask

    task automatic send_sample(input logic signed [23:0] raw, input logic [31:0] now);
        sample_ch.valid <= 1'b1;
        sample_ch.raw_sample <= raw;
        sample_ch.now_ms <= now;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        predict_weight(raw, now);
        if ($urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic idle_sender();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lcfc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (idx == lcfc_pkg::CFG_ZERO_OFFSET) tare = value[26:0];
        else if (idx == lcfc_pkg::CFG_GAIN_Q24) gain = value;
        else if (idx == lcfc_pkg::CFG_INTERVAL) interval_ms = value[15:0];
    endtask

    task automatic set_config(input logic [26:0] t, input logic [31:0] g,
                              input logic [15:0] iv);
        drain();
        write_reg(lcfc_pkg::CFG_ZERO_OFFSET, 32'(t));
        write_reg(lcfc_pkg::CFG_GAIN_Q24, g);
        write_reg(lcfc_pkg::CFG_INTERVAL, 32'(iv));
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_sample(24'sd1000, 32'd0);
        send_sample(24'sd1000, 32'd201);
        send_sample(-24'sd1000, 32'd202);
    endtask

    task automatic test_field_extremes();
        set_config(27'd0, 32'h0100_0000, 16'd1);
        send_sample(24'h7FFFFF, 32'd1000);
        send_sample(24'h800000, 32'd1001);
        send_sample(24'h7FFFFF, 32'd1003);
        send_sample(24'h000000, 32'hFFFF_FFFF);
        send_sample(24'h800000, 32'd5);
        send_sample(24'h800000, 32'd5);
        send_sample(24'h800000, 32'd5);
        // equal samples make a median tie
        send_sample(24'sd77, 32'd9);
        send_sample(24'sd77, 32'd12);
        send_sample(24'sd77, 32'd15);
        clock_ms = 15;
    endtask

    task automatic test_zero_interval();
        set_config(27'h4000000, 32'h8000_0000, 16'd0);
        send_sample(24'sd5, 32'd15);
        send_sample(24'sd5, 32'd16);
        send_sample(24'h7FFFFF, 32'd16);
        set_config(27'h3FFFFFF, 32'h7FFF_FFFF, 16'hFFFF);
        send_sample(24'h800000, 32'd17);
        send_sample(24'h800000, 32'd70000);
        clock_ms = 70000;
    endtask

    task automatic test_small_gain_tracking();
        set_config(27'd0, 32'd40000, 16'd3);
        for (int i = 0; i < 8; i++)
        begin
            clock_ms += 2;
            send_sample(24'(1000 + 20 * i), clock_ms);
        end
    endtask

    task automatic test_random_traffic(input int count);
        int sent;
        int burst;
        int level;
        sent = 0;
        while (sent < count)
        begin
            if (sent % 300 == 0)
            begin
                set_config(27'($urandom_range(0, 20000) - 10000),
                           32'($urandom_range(0, 200000) - 100000),
                           16'($urandom_range(0, 40)));
                if (sent == 600)
                    set_config(27'($urandom), $urandom, 16'($urandom_range(1, 65535)));
            end
            level = $urandom_range(0, 60000) - 30000;
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                logic signed [23:0] raw;
                case ($urandom_range(0, 9))
                    0: raw = 24'($urandom);
                    1: raw = 24'($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000);
                    default: raw = 24'(level + $urandom_range(0, 400) - 200);
                endcase
                if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
                else clock_ms += $urandom_range(0, 30);
                send_sample(raw, clock_ms);
                sent++;
            end
            if (sent % 100 < 20 && $urandom_range(0, 4) == 0)
                drain();
            else
                repeat ($urandom_range(0, 12)) idle_sender();
        end
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (!stall_enable || cycles % 2000 < 500) result_ch.ready <= 1'b1;
        else result_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        tb_lcfc_pkg::weight_word_t got;
        tb_lcfc_pkg::weight_word_t want;
        cycles++;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.weight = result_ch.weight_grams;
            got.shown = result_ch.display_weight_grams;
            got.sum = result_ch.filtered_sum;
            got.updated = result_ch.display_updated;
            words_seen++;
            if (got.updated) updates_seen++;
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word");
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.weight !== want.weight)
                begin
                    $error("weight_grams expected %0d actual %0d", want.weight, got.weight);
                    errors++;
                end
                if (got.shown !== want.shown)
                begin
                    $error("display_weight_grams expected %0d actual %0d",
                           want.shown, got.shown);
                    errors++;
                end
                if (got.sum !== want.sum)
                begin
                    $error("filtered_sum expected %0h actual %0h", want.sum, got.sum);
                    errors++;
                end
                if (got.updated !== want.updated)
                begin
                    $error("display_updated expected %0b actual %0b",
                           want.updated, got.updated);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        sample_ch.valid = 1'b0;
        sample_ch.raw_sample = '0;
        sample_ch.now_ms = '0;
        result_ch.ready = 1'b0;
        reset_predictor();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_field_extremes();
        test_zero_interval();
        test_small_gain_tracking();
        test_random_traffic(1170);
        stall_enable = 1'b0;
        drain();
        $display("covered %0d result words, %0d display updates, %0d clamped weights",
                 words_seen, updates_seen, clamps_seen);
        if (errors == 0 && expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
